[rtl/hsd_pkg.sv]
package hsd_pkg;

    localparam int COORD_W = 32;
    localparam int REG_W = 31;
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W = 33;
    localparam int PROD_W = 63;
    localparam int QUO_W = 35;
    localparam int HI_W = PROD_W - QUO_W;
    localparam int RAD_W = QUO_W + 2;
    localparam int CAP_W = COORD_W + 1;
    localparam int LATENCY = 74;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAIST_RADIUS = 3'd0,
        REG_Z_SCALE      = 3'd1,
        REG_Z_LOW_CAP    = 3'd2,
        REG_Z_HIGH_CAP   = 3'd3,
        REG_INVERT_SIGN  = 3'd4
    } cfg_reg_t;

endpackage

[rtl/hyperboloid_signed_distance_core.sv]
// One point per cycle; busy stays low, start is taken every cycle.
// Depth is set by two 32-step square roots, run side by side in one root pipe, and a 35-step divide pipe.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset (rst_n, asynchronous, active low) clears the pipeline valid bits
// and loads the configuration registers with their default shape.
module hyperboloid_signed_distance_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hsd_pkg::COORD_W-1:0]  point_x,
    input  logic signed [hsd_pkg::COORD_W-1:0]  point_y,
    input  logic signed [hsd_pkg::COORD_W-1:0]  point_z,
    input  logic                                cfg_write,
    input  logic [hsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsd_pkg::COORD_W-1:0]         cfg_data,
    output logic                                done,
    output logic signed [hsd_pkg::COORD_W-1:0]  distance
);

    localparam int CW = hsd_pkg::COORD_W;
    localparam int RW = hsd_pkg::REG_W;
    localparam int SQ_W = hsd_pkg::SQ_W;
    localparam int ROOT_W = hsd_pkg::ROOT_W;
    localparam int PROD_W = hsd_pkg::PROD_W;
    localparam int QUO_W = hsd_pkg::QUO_W;
    localparam int HI_W = hsd_pkg::HI_W;
    localparam int RAD_W = hsd_pkg::RAD_W;
    localparam int CAP_W = hsd_pkg::CAP_W;
    localparam int D_W = RAD_W + 1;

    localparam logic [RW-1:0] ONE_Q = RW'(64'd1 << FRAC_BITS);
    localparam logic signed [CW-1:0] POS_ONE_Q = CW'(64'd1 << FRAC_BITS);
    localparam logic signed [CW-1:0] NEG_ONE_Q = -POS_ONE_Q;
    localparam logic signed [RAD_W-1:0] RADIAL_FLOOR = -(RAD_W'(1) << QUO_W);
    localparam logic signed [D_W-1:0] D_MAX = D_W'(64'sd2147483647);
    localparam logic signed [D_W-1:0] D_MIN = -D_W'(64'sd2147483648);

    logic [RW-1:0]        waist_reg;
    logic [RW-1:0]        zscale_reg;
    logic signed [CW-1:0] zlow_reg;
    logic signed [CW-1:0] zhigh_reg;
    logic                 invert_reg;
    logic [RW-1:0]        zs_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waist_reg  <= ONE_Q;
            zscale_reg <= ONE_Q;
            zlow_reg   <= NEG_ONE_Q;
            zhigh_reg  <= POS_ONE_Q;
            invert_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (hsd_pkg::cfg_reg_t'(cfg_index))
                hsd_pkg::REG_WAIST_RADIUS: waist_reg  <= cfg_data[RW-1:0];
                hsd_pkg::REG_Z_SCALE:      zscale_reg <= cfg_data[RW-1:0];
                hsd_pkg::REG_Z_LOW_CAP:    zlow_reg   <= $signed(cfg_data);
                hsd_pkg::REG_Z_HIGH_CAP:   zhigh_reg  <= $signed(cfg_data);
                hsd_pkg::REG_INVERT_SIGN:  invert_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    assign zs_eff = (zscale_reg == '0) ? RW'(1) : zscale_reg;
    assign busy   = 1'b0;

    // input stage
    logic                 a_vld_reg;
    logic signed [CW-1:0] ax_reg, ay_reg, az_reg;

    // square stage
    logic                 b_vld_reg;
    logic [SQ_W-1:0]      b_sqx_reg, b_sqy_reg, b_sqz_reg, b_sqs_reg;
    logic signed [CW-1:0] b_z_reg;
    logic [CW-1:0]        mag_x, mag_y, mag_z;

    assign mag_x = ax_reg[CW-1] ? CW'(-ax_reg) : CW'(ax_reg);
    assign mag_y = ay_reg[CW-1] ? CW'(-ay_reg) : CW'(ay_reg);
    assign mag_z = az_reg[CW-1] ? CW'(-az_reg) : CW'(az_reg);

    // root pipe
    logic                 r_vld;
    logic [ROOT_W-1:0]    r_rho, r_s;
    logic signed [CW-1:0] r_z;
    logic [SQ_W-1:0]      sum_rho, sum_s;

    assign sum_rho = b_sqx_reg + b_sqy_reg;
    assign sum_s   = b_sqz_reg + b_sqs_reg;

    hsd_root_pipe u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_a      (sum_rho),
        .in_b      (sum_s),
        .in_tag    (b_z_reg),
        .out_valid (r_vld),
        .out_a     (r_rho),
        .out_b     (r_s),
        .out_tag   (r_z)
    );

    // multiply stage
    logic                 m_vld_reg;
    logic [PROD_W-1:0]    m_prod_reg;
    logic [ROOT_W-1:0]    m_rho_reg;
    logic signed [CW-1:0] m_z_reg;
    logic [HI_W-1:0]      m_hi;
    logic                 m_big;

    assign m_hi  = m_prod_reg[PROD_W-1:QUO_W];
    assign m_big = {{(RW-HI_W){1'b0}}, m_hi} >= zs_eff;

    // divide pipe
    logic                 d_vld_reg [0:QUO_W];
    logic                 d_big_reg [0:QUO_W];
    logic [RW-1:0]        d_rem_reg [0:QUO_W];
    logic [QUO_W-1:0]     d_low_reg [0:QUO_W];
    logic [QUO_W-1:0]     d_q_reg   [0:QUO_W];
    logic [ROOT_W-1:0]    d_rho_reg [0:QUO_W];
    logic signed [CW-1:0] d_z_reg   [0:QUO_W];

    // final stages
    logic                    f_vld_reg;
    logic signed [RAD_W-1:0] f_radial_reg;
    logic signed [CAP_W-1:0] f_cap_reg;
    logic signed [RAD_W-1:0] radial_next;
    logic signed [CAP_W-1:0] cap_hi, cap_lo, cap_next;
    logic signed [RAD_W-1:0] cap_ext, d_max;
    logic signed [D_W-1:0]   d_signed;
    logic signed [CW-1:0]    distance_next;
    logic                    done_reg;
    logic signed [CW-1:0]    distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            for (int i = 0; i <= QUO_W; i++)
            begin
                d_vld_reg[i] <= 1'b0;
            end
            f_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg    <= start & ~busy;
            b_vld_reg    <= a_vld_reg;
            m_vld_reg    <= r_vld;
            d_vld_reg[0] <= m_vld_reg;
            for (int i = 0; i < QUO_W; i++)
            begin
                d_vld_reg[i+1] <= d_vld_reg[i];
            end
            f_vld_reg <= d_vld_reg[QUO_W];
            done_reg  <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= point_x;
        ay_reg       <= point_y;
        az_reg       <= point_z;
        b_sqx_reg    <= SQ_W'(mag_x) * SQ_W'(mag_x);
        b_sqy_reg    <= SQ_W'(mag_y) * SQ_W'(mag_y);
        b_sqz_reg    <= SQ_W'(mag_z) * SQ_W'(mag_z);
        b_sqs_reg    <= SQ_W'(zs_eff) * SQ_W'(zs_eff);
        b_z_reg      <= az_reg;
        m_prod_reg   <= PROD_W'(waist_reg) * PROD_W'(r_s);
        m_rho_reg    <= r_rho;
        m_z_reg      <= r_z;
        d_big_reg[0] <= m_big;
        d_rem_reg[0] <= m_big ? '0 : {{(RW-HI_W){1'b0}}, m_hi};
        d_low_reg[0] <= m_prod_reg[QUO_W-1:0];
        d_q_reg[0]   <= '0;
        d_rho_reg[0] <= m_rho_reg;
        d_z_reg[0]   <= m_z_reg;
        f_radial_reg <= radial_next;
        f_cap_reg    <= cap_next;
        distance_reg <= distance_next;
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        logic [RW:0] trial;
        logic        ge;

        assign trial = {d_rem_reg[g], d_low_reg[g][QUO_W-1]};
        assign ge    = trial >= {1'b0, zs_eff};

        always_ff @(posedge clk)
        begin
            d_big_reg[g+1] <= d_big_reg[g];
            d_rem_reg[g+1] <= ge ? RW'(trial - {1'b0, zs_eff}) : trial[RW-1:0];
            d_low_reg[g+1] <= {d_low_reg[g][QUO_W-2:0], 1'b0};
            d_q_reg[g+1]   <= {d_q_reg[g][QUO_W-2:0], ge};
            d_rho_reg[g+1] <= d_rho_reg[g];
            d_z_reg[g+1]   <= d_z_reg[g];
        end
    end

    always_comb
    begin
        radial_next = d_big_reg[QUO_W] ? RADIAL_FLOOR
                    : $signed({{(RAD_W-ROOT_W){1'b0}}, d_rho_reg[QUO_W]})
                      - $signed({2'b00, d_q_reg[QUO_W]});
        cap_hi   = $signed({d_z_reg[QUO_W][CW-1], d_z_reg[QUO_W]})
                 - $signed({zhigh_reg[CW-1], zhigh_reg});
        cap_lo   = $signed({zlow_reg[CW-1], zlow_reg})
                 - $signed({d_z_reg[QUO_W][CW-1], d_z_reg[QUO_W]});
        cap_next = (cap_hi > cap_lo) ? cap_hi : cap_lo;
    end

    always_comb
    begin
        cap_ext  = {{(RAD_W-CAP_W){f_cap_reg[CAP_W-1]}}, f_cap_reg};
        d_max    = (f_radial_reg > cap_ext) ? f_radial_reg : cap_ext;
        d_signed = invert_reg ? -$signed({d_max[RAD_W-1], d_max})
                              : $signed({d_max[RAD_W-1], d_max});
        priority if (d_signed > D_MAX)
        begin
            distance_next = D_MAX[CW-1:0];
        end
        else if (d_signed < D_MIN)
        begin
            distance_next = D_MIN[CW-1:0];
        end
        else
        begin
            distance_next = d_signed[CW-1:0];
        end
    end

    assign done     = done_reg;
    assign distance = distance_reg;

endmodule

[rtl/hsd_root_pipe.sv]
module hsd_root_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [hsd_pkg::SQ_W-1:0]            in_a,
    input  logic [hsd_pkg::SQ_W-1:0]            in_b,
    input  logic signed [hsd_pkg::COORD_W-1:0]  in_tag,
    output logic                                out_valid,
    output logic [hsd_pkg::ROOT_W-1:0]          out_a,
    output logic [hsd_pkg::ROOT_W-1:0]          out_b,
    output logic signed [hsd_pkg::COORD_W-1:0]  out_tag
);

    localparam int STEPS = hsd_pkg::ROOT_W;
    localparam int SQ_W = hsd_pkg::SQ_W;
    localparam int REM_W = hsd_pkg::REM_W;
    localparam int SH_W = REM_W + 2;

    logic                               vld_reg [0:STEPS];
    logic [SQ_W-1:0]                    va_reg  [0:STEPS];
    logic [SQ_W-1:0]                    vb_reg  [0:STEPS];
    logic [REM_W-1:0]                   ra_reg  [0:STEPS];
    logic [REM_W-1:0]                   rb_reg  [0:STEPS];
    logic [STEPS-1:0]                   qa_reg  [0:STEPS];
    logic [STEPS-1:0]                   qb_reg  [0:STEPS];
    logic signed [hsd_pkg::COORD_W-1:0] tag_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < STEPS; i++)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg[0]  <= in_a;
        vb_reg[0]  <= in_b;
        ra_reg[0]  <= '0;
        rb_reg[0]  <= '0;
        qa_reg[0]  <= '0;
        qb_reg[0]  <= '0;
        tag_reg[0] <= in_tag;
    end

    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        logic [SH_W-1:0] sh_a;
        logic [SH_W-1:0] sh_b;
        logic [SH_W-1:0] tr_a;
        logic [SH_W-1:0] tr_b;
        logic            ge_a;
        logic            ge_b;

        assign sh_a = {ra_reg[g], va_reg[g][SQ_W-1:SQ_W-2]};
        assign sh_b = {rb_reg[g], vb_reg[g][SQ_W-1:SQ_W-2]};
        assign tr_a = {1'b0, qa_reg[g], 2'b01};
        assign tr_b = {1'b0, qb_reg[g], 2'b01};
        assign ge_a = sh_a >= tr_a;
        assign ge_b = sh_b >= tr_b;

        always_ff @(posedge clk)
        begin
            va_reg[g+1]  <= {va_reg[g][SQ_W-3:0], 2'b00};
            vb_reg[g+1]  <= {vb_reg[g][SQ_W-3:0], 2'b00};
            ra_reg[g+1]  <= ge_a ? REM_W'(sh_a - tr_a) : sh_a[REM_W-1:0];
            rb_reg[g+1]  <= ge_b ? REM_W'(sh_b - tr_b) : sh_b[REM_W-1:0];
            qa_reg[g+1]  <= {qa_reg[g][STEPS-2:0], ge_a};
            qb_reg[g+1]  <= {qb_reg[g][STEPS-2:0], ge_b};
            tag_reg[g+1] <= tag_reg[g];
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_a     = qa_reg[STEPS];
    assign out_b     = qb_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

[rtl/hsd_checker.sv]
module hsd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LAT = hsd_pkg::LATENCY;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer produced no result");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a transfer");

endmodule

bind hyperboloid_signed_distance_core hsd_checker u_hsd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
